// ===== rtl/core/rgb_to_yuy2_121_chroma_top_defines.svh =====
// assertion macros used by the checked top module
`ifndef RGB_TO_YUY2_121_CHROMA_TOP_DEFINES_SVH
`define RGB_TO_YUY2_121_CHROMA_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RTYC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define RTYC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/rtyc_pkg.sv =====
package rtyc_pkg;

  localparam int PIX_W       = 8;
  localparam int LCOEF_W     = 16;
  localparam int CCOEF_W     = 17;
  localparam int LACC_W      = 26;
  localparam int SUM_W       = 10;
  localparam int TVSUM_W     = 28;
  localparam int DIFF_W      = 17;
  localparam int CACC_W      = 36;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int LUMA_FRAC   = 15;

  localparam logic [LACC_W-1:0] BIAS_FULL = LACC_W'(32'h4000);
  localparam logic [LACC_W-1:0] BIAS_TV   = LACC_W'(32'h84000);

  localparam logic signed [10:0]        TV_LUMA_OFFSET4 = 11'sd64;
  localparam logic signed [TVSUM_W-1:0] TV_EXPAND       = TVSUM_W'(38155);
  localparam int CHROMA_CENTER = 128;

  // rounding terms for the chroma accumulator
  localparam logic signed [CACC_W-1:0] ROUND_FULL =
    CACC_W'((CHROMA_CENTER << (LUMA_FRAC + 2)) + (1 << (LUMA_FRAC + 1)));
  localparam logic signed [CACC_W-1:0] ROUND_TV =
    CACC_W'((CHROMA_CENTER << (LUMA_FRAC + 6)) + (1 << (LUMA_FRAC + 5)));

  localparam logic [LCOEF_W-1:0] RST_COEF_BLUE  = LCOEF_W'(3736);
  localparam logic [LCOEF_W-1:0] RST_COEF_GREEN = LCOEF_W'(19235);
  localparam logic [LCOEF_W-1:0] RST_COEF_RED   = LCOEF_W'(9798);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LUMA_BLUE  = 3'd0,
    REG_COEF_LUMA_GREEN = 3'd1,
    REG_COEF_LUMA_RED   = 3'd2,
    REG_COEF_CHROMA_U   = 3'd3,
    REG_COEF_CHROMA_V   = 3'd4,
    REG_TV_RANGE        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LCOEF_W-1:0] blue;
    logic [LCOEF_W-1:0] green;
    logic [LCOEF_W-1:0] red;
    logic               tv;
  } luma_cfg_t;

  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [CACC_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) res = '0;
    else if (v > CACC_W'(255)) res = '1;
    else res = v[PIX_W-1:0];
    return res;
  endfunction

endpackage

// ===== rtl/core/rgb_to_yuy2_121_chroma_top.sv =====
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// in_      | input     | in_valid / in_ready   | left/right blue, green, red, row_start
// out_     | output    | out_valid / out_ready | luma_left, chroma_u, luma_right, chroma_v
// cfg_     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// each word is taken and passes in turn through capture, luma lanes, kernel sums, tv luma expansion,
// chroma difference, chroma scale into the output register; each step feeds the next
// and only one word is in flight at a time
// a finished word waits in the output register while the next word is taken
// out_ready low stalls only the final step; cfg_ready is always high
// synchronous active-low reset loads default weights, full range, zero taps
`include "rgb_to_yuy2_121_chroma_top_defines.svh"

module rgb_to_yuy2_121_chroma_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rtyc_pkg::PIX_W-1:0]           in_left_blue,
  input  logic [rtyc_pkg::PIX_W-1:0]           in_left_green,
  input  logic [rtyc_pkg::PIX_W-1:0]           in_left_red,
  input  logic [rtyc_pkg::PIX_W-1:0]           in_right_blue,
  input  logic [rtyc_pkg::PIX_W-1:0]           in_right_green,
  input  logic [rtyc_pkg::PIX_W-1:0]           in_right_red,
  input  logic                                 in_row_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rtyc_pkg::PIX_W-1:0]           out_luma_left,
  output logic [rtyc_pkg::PIX_W-1:0]           out_chroma_u,
  output logic [rtyc_pkg::PIX_W-1:0]           out_luma_right,
  output logic [rtyc_pkg::PIX_W-1:0]           out_chroma_v,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rtyc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rtyc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rtyc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA,
    ST_SUM,
    ST_EXPAND,
    ST_DIFF,
    ST_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  luma_cfg_t            luma_cfg_r;
  logic [CCOEF_W-1:0]   coef_u_r, coef_v_r;

  // captured word
  logic [PIX_W-1:0] lb_r, lg_r, lr_r, rb_r, rg_r, rr_r;
  logic             start_r;

  // luma results and 1-2-1 taps
  logic [PIX_W-1:0] yl_nxt, yr_nxt, yl_r, yr_r;
  logic [PIX_W-1:0] prior_blue_r, prior_red_r, prior_luma_r;
  logic [PIX_W-1:0] pb, pr, py;

  // kernel sums
  logic [SUM_W-1:0]          ysum_nxt, bsum_nxt, rsum_nxt;
  logic [SUM_W-1:0]          ysum_r, bsum_r, rsum_r;
  logic signed [TVSUM_W-1:0] ysum_off, ysum_tv_r;

  logic [PIX_W-1:0] chroma_u, chroma_v;
  logic             load_diff;
  logic             out_valid_r;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign load_diff = (state_r == ST_DIFF);

  // two luma lanes, one per pixel of the pair
  rtyc_luma_lane u_luma_left (
    .cfg   (luma_cfg_r),
    .blue  (lb_r),
    .green (lg_r),
    .red   (lr_r),
    .luma  (yl_nxt)
  );

  rtyc_luma_lane u_luma_right (
    .cfg   (luma_cfg_r),
    .blue  (rb_r),
    .green (rg_r),
    .red   (rr_r),
    .luma  (yr_nxt)
  );

  // row start folds the previous-pixel tap onto the left pixel
  assign pb = start_r ? lb_r : prior_blue_r;
  assign pr = start_r ? lr_r : prior_red_r;
  assign py = start_r ? yl_r : prior_luma_r;

  assign ysum_nxt = SUM_W'(py) + SUM_W'({yl_r, 1'b0}) + SUM_W'(yr_r);
  assign bsum_nxt = SUM_W'(pb) + SUM_W'({lb_r, 1'b0}) + SUM_W'(rb_r);
  assign rsum_nxt = SUM_W'(pr) + SUM_W'({lr_r, 1'b0}) + SUM_W'(rr_r);

  // tv range luma kernel with the black offset removed, shared by both chroma lanes
  assign ysum_off = TVSUM_W'($signed({1'b0, ysum_r}) - TV_LUMA_OFFSET4);

  // chroma lanes, merged into one word at the output register
  rtyc_chroma_lane u_chroma_u (
    .clk         (clk),
    .load_diff   (load_diff),
    .tv          (luma_cfg_r.tv),
    .comp_sum    (bsum_r),
    .luma_sum    (ysum_r),
    .luma_sum_tv (ysum_tv_r),
    .coef        (coef_u_r),
    .chroma      (chroma_u)
  );

  rtyc_chroma_lane u_chroma_v (
    .clk         (clk),
    .load_diff   (load_diff),
    .tv          (luma_cfg_r.tv),
    .comp_sum    (rsum_r),
    .luma_sum    (ysum_r),
    .luma_sum_tv (ysum_tv_r),
    .coef        (coef_v_r),
    .chroma      (chroma_v)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_cfg_r.blue  <= RST_COEF_BLUE;
      luma_cfg_r.green <= RST_COEF_GREEN;
      luma_cfg_r.red   <= RST_COEF_RED;
      luma_cfg_r.tv    <= 1'b0;
      coef_u_r         <= '0;
      coef_v_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_LUMA_BLUE:  luma_cfg_r.blue  <= cfg_data[LCOEF_W-1:0];
        REG_COEF_LUMA_GREEN: luma_cfg_r.green <= cfg_data[LCOEF_W-1:0];
        REG_COEF_LUMA_RED:   luma_cfg_r.red   <= cfg_data[LCOEF_W-1:0];
        REG_COEF_CHROMA_U:   coef_u_r         <= cfg_data;
        REG_COEF_CHROMA_V:   coef_v_r         <= cfg_data;
        REG_TV_RANGE:        luma_cfg_r.tv    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, taps and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      prior_blue_r <= '0;
      prior_red_r  <= '0;
      prior_luma_r <= '0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            lb_r    <= in_left_blue;
            lg_r    <= in_left_green;
            lr_r    <= in_left_red;
            rb_r    <= in_right_blue;
            rg_r    <= in_right_green;
            rr_r    <= in_right_red;
            start_r <= in_row_start;
            state_r <= ST_LUMA;
          end
        end
        ST_LUMA: begin
          yl_r    <= yl_nxt;
          yr_r    <= yr_nxt;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          ysum_r       <= ysum_nxt;
          bsum_r       <= bsum_nxt;
          rsum_r       <= rsum_nxt;
          prior_blue_r <= rb_r;
          prior_red_r  <= rr_r;
          prior_luma_r <= yr_r;
          state_r      <= ST_EXPAND;
        end
        ST_EXPAND: begin
          ysum_tv_r <= ysum_off * TV_EXPAND;
          state_r   <= ST_DIFF;
        end
        ST_DIFF: begin
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_luma_left  <= yl_r;
            out_luma_right <= yr_r;
            out_chroma_u   <= chroma_u;
            out_chroma_v   <= chroma_v;
            out_valid_r    <= 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a taken word always moves on to the luma lanes
  `RTYC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == ST_LUMA)
  // the last step with a free output register always presents a word
  `RTYC_ASSERT_NEXT(a_out_loaded, state_r == ST_OUT && !out_valid_r, out_valid_r)
  // the stored luma tap follows the right pixel of the word just summed
  `RTYC_ASSERT_NEXT(a_prior_tracks_right, state_r == ST_SUM, prior_luma_r == $past(yr_r))

endmodule

// ===== rtl/core/rtyc_luma_lane.sv =====
module rtyc_luma_lane (
  input  rtyc_pkg::luma_cfg_t         cfg,
  input  logic [rtyc_pkg::PIX_W-1:0]  blue,
  input  logic [rtyc_pkg::PIX_W-1:0]  green,
  input  logic [rtyc_pkg::PIX_W-1:0]  red,
  output logic [rtyc_pkg::PIX_W-1:0]  luma
);
  import rtyc_pkg::*;

  localparam int PROD_W = LCOEF_W + PIX_W;

  logic [PROD_W-1:0] prod_b, prod_g, prod_r;
  logic [LACC_W-1:0] acc;

  assign prod_b = PROD_W'(cfg.blue)  * PROD_W'(blue);
  assign prod_g = PROD_W'(cfg.green) * PROD_W'(green);
  assign prod_r = PROD_W'(cfg.red)   * PROD_W'(red);

  assign acc = LACC_W'(prod_b) + LACC_W'(prod_g) + LACC_W'(prod_r)
             + (cfg.tv ? BIAS_TV : BIAS_FULL);

  // saturate anything above 255 after the fraction is dropped
  assign luma = (|acc[LACC_W-1:LUMA_FRAC+PIX_W]) ? '1 : acc[LUMA_FRAC+PIX_W-1:LUMA_FRAC];

endmodule

// ===== rtl/core/rtyc_chroma_lane.sv =====
module rtyc_chroma_lane (
  input  logic                                clk,
  input  logic                                load_diff,
  input  logic                                tv,
  input  logic [rtyc_pkg::SUM_W-1:0]          comp_sum,
  input  logic [rtyc_pkg::SUM_W-1:0]          luma_sum,
  input  logic signed [rtyc_pkg::TVSUM_W-1:0] luma_sum_tv,
  input  logic [rtyc_pkg::CCOEF_W-1:0]        coef,
  output logic [rtyc_pkg::PIX_W-1:0]          chroma
);
  import rtyc_pkg::*;

  logic signed [SUM_W:0]        diff_full;
  logic signed [TVSUM_W-1:0]    diff_tv;
  logic signed [DIFF_W-1:0]     diff_nxt, diff_r;
  logic signed [CACC_W-1:0]     prod, acc, shifted;

  // stage one: component kernel minus luma kernel
  assign diff_full = $signed({1'b0, comp_sum}) - $signed({1'b0, luma_sum});
  assign diff_tv   = $signed(TVSUM_W'({comp_sum, {LUMA_FRAC{1'b0}}})) - luma_sum_tv;
  assign diff_nxt  = tv ? DIFF_W'(diff_tv >>> (LUMA_FRAC - 4))
                        : DIFF_W'(diff_full);

  always_ff @(posedge clk) begin
    if (load_diff) begin
      diff_r <= diff_nxt;
    end
  end

  // stage two: scale, center, round, clamp
  assign prod    = CACC_W'(diff_r) * $signed({{(CACC_W-CCOEF_W){1'b0}}, coef});
  assign acc     = prod + (tv ? ROUND_TV : ROUND_FULL);
  assign shifted = tv ? (acc >>> (LUMA_FRAC + 6)) : (acc >>> (LUMA_FRAC + 2));
  assign chroma  = clamp_byte(shifted);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // six-step conversion plus the output register, with some margin
  localparam int SETTLE_CYCLES = 12;
  // cycles with no word moving on any channel before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;

  // register indexes past the end of the map, the block must ignore them
  localparam logic [rtyc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [rtyc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // fixed-point constants of the conversion
  localparam longint LUMA_BIAS_FULL = 'h4000;    // 0.5 in 15 fractional bits
  localparam longint LUMA_BIAS_TV   = 'h84000;   // 16.5 in 15 fractional bits
  localparam int     LUMA_SHIFT     = 15;
  localparam longint TV_SUM_OFFSET  = 16 * 4;    // 16 times the kernel weight sum of four
  localparam longint TV_GAIN        = 38155;     // 255 / 219 in 15 fractional bits
  localparam int     FULL_SHIFT     = 17;
  localparam longint FULL_ROUND     = (longint'(128) << 17) + (longint'(1) << 16);
  localparam int     TV_PRESHIFT    = 11;
  localparam int     TV_SHIFT       = 21;
  localparam longint TV_ROUND       = (longint'(128) << 21) + (longint'(1) << 20);

  typedef logic [rtyc_pkg::PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t lb, lg, lr;
    pix_t rb, rg, rr;
    logic row_start;
  } pair_t;

  typedef struct packed {
    pix_t luma_left;
    pix_t chroma_u;
    pix_t luma_right;
    pix_t chroma_v;
  } yuy2_group_t;

  localparam int PAIR_W = $bits(pair_t);

  // ---------------------------------------------------------------------------
  // block ports, every input known from time zero
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid       = 1'b0;
  logic in_ready;
  pix_t in_left_blue   = '0;
  pix_t in_left_green  = '0;
  pix_t in_left_red    = '0;
  pix_t in_right_blue  = '0;
  pix_t in_right_green = '0;
  pix_t in_right_red   = '0;
  logic in_row_start   = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  pix_t out_luma_left;
  pix_t out_chroma_u;
  pix_t out_luma_right;
  pix_t out_chroma_v;

  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rtyc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [rtyc_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

  rgb_to_yuy2_121_chroma_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_blue   (in_left_blue),
    .in_left_green  (in_left_green),
    .in_left_red    (in_left_red),
    .in_right_blue  (in_right_blue),
    .in_right_green (in_right_green),
    .in_right_red   (in_right_red),
    .in_row_start   (in_row_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_luma_left  (out_luma_left),
    .out_chroma_u   (out_chroma_u),
    .out_luma_right (out_luma_right),
    .out_chroma_v   (out_chroma_v),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the register file and the filter taps
  // ---------------------------------------------------------------------------
  logic [rtyc_pkg::LCOEF_W-1:0] w_blue  = rtyc_pkg::RST_COEF_BLUE;
  logic [rtyc_pkg::LCOEF_W-1:0] w_green = rtyc_pkg::RST_COEF_GREEN;
  logic [rtyc_pkg::LCOEF_W-1:0] w_red   = rtyc_pkg::RST_COEF_RED;
  logic [rtyc_pkg::CCOEF_W-1:0] scale_u = '0;
  logic [rtyc_pkg::CCOEF_W-1:0] scale_v = '0;
  logic                         tv_mode = 1'b0;

  // right pixel of the previous pair: blue, red and its luma
  pix_t tap_blue = '0;
  pix_t tap_red  = '0;
  pix_t tap_luma = '0;

  yuy2_group_t pending_groups[$];

  int   pairs_sent      = 0;
  int   groups_checked  = 0;
  int   settings_loaded = 0;
  int   mismatches      = 0;
  int   quiet_cycles    = 0;
  int   tx_gap_pct      = 0;   // chance in percent of a gap before a pair
  logic steady          = 1'b0; // no idling on either side

  function automatic pix_t sat_byte(input longint v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return pix_t'(v);
  endfunction

  function automatic pix_t pixel_luma(input pix_t b, input pix_t g, input pix_t r);
    longint kb, kg, kr, acc;
    kb  = w_blue;
    kg  = w_green;
    kr  = w_red;
    acc = kb * longint'(b) + kg * longint'(g) + kr * longint'(r)
        + (tv_mode ? LUMA_BIAS_TV : LUMA_BIAS_FULL);
    // weights above unity push luma past 255, it saturates
    return sat_byte(acc >>> LUMA_SHIFT);
  endfunction

  function automatic pix_t filtered_chroma(input longint comp_sum, input longint luma_sum,
                                           input longint k);
    longint d, acc;
    if (!tv_mode) begin
      d   = comp_sum - luma_sum;
      acc = d * k + FULL_ROUND;
      return sat_byte(acc >>> FULL_SHIFT);
    end
    // limited range: luma is expanded back to full scale before the difference
    d   = comp_sum * 32768 - (luma_sum - TV_SUM_OFFSET) * TV_GAIN;
    acc = (d >>> TV_PRESHIFT) * k + TV_ROUND;
    return sat_byte(acc >>> TV_SHIFT);
  endfunction

  // one pair in, one yuy2 group out; advances the filter taps
  function automatic yuy2_group_t convert_pair(input pair_t p);
    pix_t        yl, yr, pb, pr, py;
    longint      ysum, bsum, rsum, ku, kv;
    yuy2_group_t g;
    yl = pixel_luma(p.lb, p.lg, p.lr);
    yr = pixel_luma(p.rb, p.rg, p.rr);
    // a row start has no left neighbor, the left pixel stands in for it
    pb = p.row_start ? p.lb : tap_blue;
    pr = p.row_start ? p.lr : tap_red;
    py = p.row_start ? yl   : tap_luma;
    ysum = longint'(py) + 2 * longint'(yl) + longint'(yr);
    bsum = longint'(pb) + 2 * longint'(p.lb) + longint'(p.rb);
    rsum = longint'(pr) + 2 * longint'(p.lr) + longint'(p.rr);
    ku = scale_u;
    kv = scale_v;
    g.luma_left  = yl;
    g.chroma_u   = filtered_chroma(bsum, ysum, ku);
    g.luma_right = yr;
    g.chroma_v   = filtered_chroma(rsum, ysum, kv);
    tap_blue = p.rb;
    tap_red  = p.rr;
    tap_luma = yr;
    return g;
  endfunction

  function automatic pair_t pixel_pair(input pix_t lb, input pix_t lg, input pix_t lr,
                                       input pix_t rb, input pix_t rg, input pix_t rr,
                                       input logic rs);
    pair_t p;
    p = '{lb: lb, lg: lg, lr: lr, rb: rb, rg: rg, rr: rr, row_start: rs};
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare against the oldest pending group
  // ---------------------------------------------------------------------------
  initial begin : result_pacing
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        // mostly short ready bursts, now and then a long stall-free stretch
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
        if (!steady) begin
          // a stall is cut short once the closing stretch begins
          n = $urandom_range(1, 11);
          out_ready <= 1'b0;
          while (n > 0 && !steady) begin
            @(posedge clk);
            n--;
          end
        end
      end
    end
  end

  function automatic void check_field(input string name, input pix_t want, input pix_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : group_checker
    yuy2_group_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_groups.size() == 0) begin
        $error("yuy2 word with no pixel pair pending");
        mismatches++;
      end else begin
        want = pending_groups.pop_front();
        check_field("luma_left",  want.luma_left,  out_luma_left);
        check_field("chroma_u",   want.chroma_u,   out_chroma_u);
        check_field("luma_right", want.luma_right, out_luma_right);
        check_field("chroma_v",   want.chroma_v,   out_chroma_v);
        groups_checked++;
      end
    end
  end

  // hang detection: nothing moving on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one pair, optionally after a gap, and record its expected group
  task automatic send_pair(input pair_t p);
    int gap;
    gap = 0;
    if (!steady && tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct)
      gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_left_blue   <= p.lb;
    in_left_green  <= p.lg;
    in_left_red    <= p.lr;
    in_right_blue  <= p.rb;
    in_right_green <= p.rg;
    in_right_red   <= p.rr;
    in_row_start   <= p.row_start;
    do @(posedge clk); while (!in_ready);
    pending_groups.push_back(convert_pair(p));
    pairs_sent++;
  endtask

  // stop sending and let every pending group drain out of the block
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so that writes can go back to back
  task automatic program_reg(input logic [rtyc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtyc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rtyc_pkg::REG_COEF_LUMA_BLUE:  w_blue  = data[rtyc_pkg::LCOEF_W-1:0];
      rtyc_pkg::REG_COEF_LUMA_GREEN: w_green = data[rtyc_pkg::LCOEF_W-1:0];
      rtyc_pkg::REG_COEF_LUMA_RED:   w_red   = data[rtyc_pkg::LCOEF_W-1:0];
      rtyc_pkg::REG_COEF_CHROMA_U:   scale_u = data;
      rtyc_pkg::REG_COEF_CHROMA_V:   scale_v = data;
      rtyc_pkg::REG_TV_RANGE:        tv_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [16:0] blue, input logic [16:0] green,
                               input logic [16:0] red, input logic [16:0] ku,
                               input logic [16:0] kv, input logic [16:0] tv);
    settle();
    program_reg(rtyc_pkg::REG_COEF_LUMA_BLUE,  blue);
    program_reg(rtyc_pkg::REG_COEF_LUMA_GREEN, green);
    program_reg(rtyc_pkg::REG_COEF_LUMA_RED,   red);
    program_reg(rtyc_pkg::REG_COEF_CHROMA_U,   ku);
    program_reg(rtyc_pkg::REG_COEF_CHROMA_V,   kv);
    program_reg(rtyc_pkg::REG_TV_RANGE,        tv);
    close_cfg();
    settings_loaded++;
  endtask

  function automatic logic [16:0] pick_luma_weight();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd32768;
      2:       return 17'($urandom);   // upper bit set now and then, dropped by the block
      3:       return 17'($urandom_range(0, 32768));
      default: return 17'($urandom_range(2500, 19000));
    endcase
  endfunction

  function automatic logic [16:0] pick_chroma_scale();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'h1FFFF;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(8000, 40000));
    endcase
  endfunction

  task automatic load_random_settings();
    load_settings(pick_luma_weight(), pick_luma_weight(), pick_luma_weight(),
                  pick_chroma_scale(), pick_chroma_scale(), 17'($urandom));
  endtask

  // rows of random pixels; a few pairs carry a wrong row marker or saturated channels
  task automatic send_rows(input int count);
    pair_t p;
    int    row_left;
    int    k;
    row_left = 0;
    for (k = 0; k < count; k++) begin
      p = PAIR_W'({$urandom, $urandom});
      p.row_start = (row_left == 0);
      if (row_left == 0) begin
        row_left = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 15;
          default: tx_gap_pct = 45;
        endcase
      end
      row_left--;
      case ($urandom_range(0, 19))
        0: p.row_start = ~p.row_start;   // stray or missing row start
        1: begin
          p.lb = {8{1'($urandom)}};
          p.lg = {8{1'($urandom)}};
          p.lr = {8{1'($urandom)}};
          p.rb = {8{1'($urandom)}};
          p.rg = {8{1'($urandom)}};
          p.rr = {8{1'($urandom)}};
        end
        default: ;
      endcase
      send_pair(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // first pair after reset has no row start, so the zeroed taps feed the filter;
  // V scale is left at its reset value of zero
  task automatic test_reset_state();
    tx_gap_pct = 30;
    program_reg(rtyc_pkg::REG_COEF_CHROMA_U, 17'd18492);
    close_cfg();
    send_pair(pixel_pair(200, 100, 50, 10, 20, 30, 1'b0));
    send_pair(pixel_pair(255, 255, 255, 255, 255, 255, 1'b0));
    send_pair(pixel_pair(0, 0, 0, 255, 255, 255, 1'b1));
  endtask

  task automatic test_full_range();
    load_settings(17'd3736, 17'd19235, 17'd9798, 17'd18492, 17'd23372, 17'd0);
    send_pair(pixel_pair(0, 0, 0, 0, 0, 0, 1'b1));
    send_pair(pixel_pair(255, 255, 255, 255, 255, 255, 1'b0));
    send_pair(pixel_pair(255, 0, 0, 255, 0, 0, 1'b0));
    send_pair(pixel_pair(0, 0, 255, 0, 0, 255, 1'b1));
    send_pair(pixel_pair(0, 255, 0, 128, 128, 128, 1'b0));
  endtask

  // full-scale chroma gain drives U and V against both rails
  task automatic test_chroma_clamp();
    load_settings(17'd3736, 17'd19235, 17'd9798, 17'h1FFFF, 17'h1FFFF, 17'd0);
    send_pair(pixel_pair(255, 0, 0, 255, 0, 0, 1'b1));
    send_pair(pixel_pair(0, 255, 255, 0, 255, 255, 1'b0));
    send_pair(pixel_pair(0, 0, 255, 255, 255, 0, 1'b0));
  endtask

  task automatic test_tv_range();
    load_settings(17'd3208, 17'd16519, 17'd8414, 17'd21043, 17'd26608, 17'd1);
    send_pair(pixel_pair(0, 0, 0, 0, 0, 0, 1'b1));
    send_pair(pixel_pair(255, 255, 255, 255, 255, 255, 1'b0));
    send_pair(pixel_pair(255, 0, 0, 255, 0, 0, 1'b0));
    send_pair(pixel_pair(0, 0, 255, 0, 0, 255, 1'b1));
    send_pair(pixel_pair(255, 0, 255, 0, 255, 0, 1'b0));
  endtask

  // weights summing far above unity: saturated luma feeds the filter and the taps;
  // the blue write also carries a bit above the register width
  task automatic test_luma_saturation();
    load_settings(17'h18000, 17'd32768, 17'd32768, 17'h1FFFF, 17'd0, 17'd0);
    send_pair(pixel_pair(255, 255, 255, 255, 255, 255, 1'b1));
    send_pair(pixel_pair(0, 0, 0, 255, 255, 255, 1'b0));
    send_pair(pixel_pair(255, 0, 0, 0, 0, 0, 1'b0));
  endtask

  task automatic test_unused_index();
    settle();
    program_reg(REG_UNUSED_LO, 17'h1FFFF);
    program_reg(REG_UNUSED_HI, 17'h00000);
    close_cfg();
    send_pair(PAIR_W'({$urandom, $urandom}));
    send_pair(PAIR_W'({$urandom, $urandom}));
  endtask

  // random settings per phase, random rows within; the first phase, and now and then a later
  // one, holds the sender midway until the block has drained completely
  task automatic test_random_rows(input int count);
    int done;
    int phase_len;
    int phase;
    done  = 0;
    phase = 0;
    while (done < count) begin
      load_random_settings();
      phase_len = $urandom_range(150, 300);
      send_rows(phase_len / 2);
      if (phase == 0 || $urandom_range(0, 2) == 0)
        settle();
      send_rows(phase_len - phase_len / 2);
      done += phase_len;
      phase++;
    end
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_steady_stream(input int count);
    steady = 1'b1;
    load_random_settings();
    send_rows(count);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_full_range();
    test_chroma_clamp();
    test_tv_range();
    test_luma_saturation();
    test_unused_index();
    test_random_rows(1750);
    test_steady_stream(230);
    settle();

    $display("%0d pixel pairs sent, %0d yuy2 words checked, %0d register settings loaded",
             pairs_sent, groups_checked, settings_loaded);
    $display("full and tv range, row starts, luma saturation, chroma clamping, unused indexes");
    if (mismatches == 0 && pending_groups.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== rgb_to_yuy2_121_chroma_top.f =====
+incdir+rtl/core
rtl/core/rtyc_pkg.sv
rtl/core/rtyc_luma_lane.sv
rtl/core/rtyc_chroma_lane.sv
rtl/core/rgb_to_yuy2_121_chroma_top.sv
tb/testbench.sv
